@@ rtl/tslsb_pkg.sv @@
package tslsb_pkg;

  localparam int SYMBOLS = 32;
  localparam int SETS    = 16;
  localparam int SET_W   = $clog2(SETS);
  localparam int ROW_W   = $clog2(SYMBOLS);
  localparam int ADDR_W  = SET_W + ROW_W;
  localparam int DEPTH   = SETS * SYMBOLS;

  typedef enum logic [2:0] {
    K_CLEAR   = 3'd0,
    K_ADD     = 3'd1,
    K_UNION   = 3'd2,
    K_MAXU    = 3'd3,
    K_APPTOK  = 3'd4,
    K_APPSET  = 3'd5,
    K_RDFIRST = 3'd6,
    K_RDROW   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRC,
    ST_TGT,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] target_set;
    logic [3:0] source_set;
    logic [4:0] token_a;
    logic [4:0] token_b;
    logic [1:0] string_length;
  } req_t;

  typedef struct packed {
    logic [31:0] symbol_bits;
    logic        has_null;
    logic        is_full;
    logic        is_empty;
  } res_t;

  // per-slot scalar part of one set
  typedef struct packed {
    logic [SYMBOLS-1:0] first;
    logic [SYMBOLS-1:0] single;
    logic               nul;
    logic               full;
    logic               empty;
  } slot_t;

  function automatic logic [SYMBOLS-1:0] sym_bit(input logic [4:0] s);
    logic [SYMBOLS-1:0] r;
    r = '0;
    if (32'(s) < SYMBOLS) r[s[ROW_W-1:0]] = 1'b1;
    return r;
  endfunction

endpackage

@@ rtl/two_symbol_lookahead_set_bank.sv @@
// Bank of 16 lookahead sets over strings cut to two symbols. Each request carries one
// command for a target slot and returns one result describing that slot afterwards.
// A request is taken only in the idle state. The source and target slot words are
// fetched in the ST_SRC and ST_TGT states, then the walk state reads, merges and
// writes back the 32 second-symbol rows of the target slot, one row per cycle, through
// the follow-row memory (two read ports, one write port). The done state then commits
// the slot word and loads the result register; only after that commit does the bank
// return to idle and take the next request. A result still stalled at commit time
// holds the bank until it is taken. After reset a clearing pass zeroes all 512 rows
// of the follow-row memory; requests are stalled until it ends.
module two_symbol_lookahead_set_bank (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  tslsb_pkg::req_t  req,
  output logic             res_valid,
  input  logic             res_stall,
  output tslsb_pkg::res_t  res
);

  localparam int SYM = tslsb_pkg::SYMBOLS;

  tslsb_pkg::state_t state, state_next;

  logic [SYM-1:0] follow_mem [tslsb_pkg::DEPTH];
  logic [SYM-1:0] first_bits  [tslsb_pkg::SETS];
  logic [SYM-1:0] single_bits [tslsb_pkg::SETS];
  logic           null_flags  [tslsb_pkg::SETS];
  logic           full_flags  [tslsb_pkg::SETS];
  logic           empty_flags [tslsb_pkg::SETS];

  tslsb_pkg::req_t  cur;
  tslsb_pkg::slot_t src, tgt, fin;
  logic [tslsb_pkg::ADDR_W:0]   clr_cnt;
  logic [tslsb_pkg::ROW_W:0]    cnt;
  logic                         pipe_v;
  logic [tslsb_pkg::ROW_W-1:0]  pipe_row;
  logic [SYM-1:0]               rd_t, rd_s, row_new, nonempty, row_cap;
  logic [tslsb_pkg::SET_W-1:0]  t_idx, s_idx, rd_idx;
  logic                         same, mem_we;
  logic [tslsb_pkg::ADDR_W-1:0] mem_wa;
  logic [SYM-1:0]               mem_wd;
  logic [1:0]                   len;
  logic                         commit;

  assign t_idx  = cur.target_set[tslsb_pkg::SET_W-1:0];
  assign s_idx  = cur.source_set[tslsb_pkg::SET_W-1:0];
  assign same   = (t_idx == s_idx);
  assign len    = (cur.string_length == 2'd3) ? 2'd2 : cur.string_length;
  assign rd_idx = (state == tslsb_pkg::ST_SRC) ? s_idx : t_idx;
  assign commit = (state == tslsb_pkg::ST_DONE) && (!res_valid || !res_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tslsb_pkg::ST_CLEAR: if (clr_cnt == (tslsb_pkg::ADDR_W+1)'(tslsb_pkg::DEPTH - 1)) begin
        state_next = tslsb_pkg::ST_IDLE;
      end
      tslsb_pkg::ST_IDLE: if (req_valid) begin
        state_next = tslsb_pkg::ST_SRC;
      end
      tslsb_pkg::ST_SRC: state_next = tslsb_pkg::ST_TGT;
      tslsb_pkg::ST_TGT: state_next = tslsb_pkg::ST_WALK;
      tslsb_pkg::ST_WALK: if (cnt == (tslsb_pkg::ROW_W+1)'(SYM)) begin
        state_next = tslsb_pkg::ST_DONE;
      end
      tslsb_pkg::ST_DONE: if (commit) begin
        state_next = tslsb_pkg::ST_IDLE;
      end
      default: state_next = tslsb_pkg::ST_IDLE;
    endcase
  end

  // merged row for the row coming out of memory
  always_comb begin
    logic [SYM-1:0] r1;
    r1 = rd_t;
    row_new = rd_t;
    case (cur.kind)
      tslsb_pkg::K_CLEAR: row_new = '0;
      tslsb_pkg::K_ADD: if (len == 2'd2 && pipe_row == cur.token_a[tslsb_pkg::ROW_W-1:0]) begin
        row_new = rd_t | tslsb_pkg::sym_bit(cur.token_b);
      end
      tslsb_pkg::K_UNION, tslsb_pkg::K_MAXU: if (!src.empty) begin
        row_new = rd_t | rd_s;
      end
      tslsb_pkg::K_APPTOK: if (tgt.single[pipe_row]) begin
        row_new = rd_t | tslsb_pkg::sym_bit(cur.token_a);
      end
      tslsb_pkg::K_APPSET: if (!src.empty) begin
        if (!tgt.empty && tgt.single[pipe_row]) r1 = rd_t | src.first;
        row_new = tgt.nul ? (r1 | rd_s) : r1;
      end
      default: row_new = rd_t;
    endcase
  end

  // memory write control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {t_idx, pipe_row};
    mem_wd = row_new;
    case (state)
      tslsb_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt[tslsb_pkg::ADDR_W-1:0];
        mem_wd = '0;
      end
      tslsb_pkg::ST_WALK: begin
        mem_we = pipe_v && (cur.kind != tslsb_pkg::K_RDFIRST) && (cur.kind != tslsb_pkg::K_RDROW);
      end
      default: mem_we = 1'b0;
    endcase
  end

  // scalar slot update
  always_comb begin
    logic sn, sf;
    fin = tgt;
    sn  = 1'b0;
    sf  = 1'b0;
    case (cur.kind)
      tslsb_pkg::K_CLEAR: begin
        fin = '0;
        fin.empty = 1'b1;
      end
      tslsb_pkg::K_ADD: begin
        if (len == 2'd0) begin
          fin.nul = 1'b1;
        end else if (len == 2'd1) begin
          fin.single = tgt.single | tslsb_pkg::sym_bit(cur.token_a);
          fin.first  = tgt.first | tslsb_pkg::sym_bit(cur.token_a);
          fin.full   = 1'b0;
          fin.empty  = 1'b0;
        end else begin
          fin.first = tgt.first | tslsb_pkg::sym_bit(cur.token_a);
          if (tgt.empty) begin
            fin.empty = 1'b0;
            fin.full  = 1'b1;
          end
        end
      end
      tslsb_pkg::K_UNION: begin
        if (src.nul) fin.nul = 1'b1;
        if (!src.empty) begin
          fin.first  = tgt.first | src.first;
          fin.single = tgt.single | src.single;
          if (tgt.empty && src.full) fin.full = 1'b1;
          fin.empty = 1'b0;
        end
      end
      tslsb_pkg::K_MAXU: if (!src.empty) begin
        fin.first = tgt.first | nonempty;
        if (tgt.empty) begin
          fin.empty = 1'b0;
          fin.full  = 1'b1;
        end
      end
      tslsb_pkg::K_APPTOK: begin
        fin.single = '0;
        if (tgt.nul) begin
          fin.nul    = 1'b0;
          fin.first  = tgt.first | tslsb_pkg::sym_bit(cur.token_a);
          fin.single = tslsb_pkg::sym_bit(cur.token_a);
          fin.full   = 1'b0;
          fin.empty  = 1'b0;
        end else if (!tgt.empty) begin
          fin.full = 1'b1;
        end
      end
      tslsb_pkg::K_APPSET: if (!src.empty) begin
        if (!tgt.empty && !src.nul) begin
          fin.single = '0;
          if (!tgt.nul) fin.full = 1'b1;
        end
        if (tgt.nul) begin
          fin.nul = 1'b0;
          // with source equal to target, the source flags are the live ones
          sn = same ? 1'b0 : src.nul;
          sf = same ? fin.full : src.full;
          if (sn) fin.nul = 1'b1;
          fin.first  = fin.first | src.first;
          fin.single = fin.single | (same ? fin.single : src.single);
          if (tgt.empty && sf) fin.full = 1'b1;
          fin.empty = 1'b0;
        end
      end
      default: fin = tgt;
    endcase
  end

  // outputs
  always_comb begin
    req_stall = (state != tslsb_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (mem_we) follow_mem[mem_wa] <= mem_wd;
    rd_t <= follow_mem[{t_idx, cnt[tslsb_pkg::ROW_W-1:0]}];
    rd_s <= follow_mem[{s_idx, cnt[tslsb_pkg::ROW_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tslsb_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      cnt       <= '0;
      pipe_v    <= 1'b0;
      res_valid <= 1'b0;
      for (int k = 0; k < tslsb_pkg::SETS; k++) begin
        first_bits[k]  <= '0;
        single_bits[k] <= '0;
        null_flags[k]  <= 1'b0;
        full_flags[k]  <= 1'b0;
        empty_flags[k] <= 1'b1;
      end
    end else begin
      state <= state_next;
      if (res_valid && !res_stall && !commit) res_valid <= 1'b0;
      case (state)
        tslsb_pkg::ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        tslsb_pkg::ST_IDLE: if (req_valid) begin
          cur <= req;
        end
        tslsb_pkg::ST_SRC: begin
          src      <= {first_bits[rd_idx], single_bits[rd_idx], null_flags[rd_idx],
                       full_flags[rd_idx], empty_flags[rd_idx]};
          nonempty <= '0;
          cnt      <= '0;
          pipe_v   <= 1'b0;
        end
        tslsb_pkg::ST_TGT: begin
          tgt <= {first_bits[rd_idx], single_bits[rd_idx], null_flags[rd_idx],
                  full_flags[rd_idx], empty_flags[rd_idx]};
        end
        tslsb_pkg::ST_WALK: begin
          pipe_v   <= (cnt < (tslsb_pkg::ROW_W+1)'(SYM));
          pipe_row <= cnt[tslsb_pkg::ROW_W-1:0];
          if (cnt < (tslsb_pkg::ROW_W+1)'(SYM)) cnt <= cnt + 1'b1;
          if (pipe_v) begin
            if (rd_t != '0) nonempty[pipe_row] <= 1'b1;
            if (pipe_row == cur.token_a[tslsb_pkg::ROW_W-1:0]) row_cap <= rd_t;
          end
        end
        tslsb_pkg::ST_DONE: if (commit) begin
          first_bits[t_idx]  <= fin.first;
          single_bits[t_idx] <= fin.single;
          null_flags[t_idx]  <= fin.nul;
          full_flags[t_idx]  <= fin.full;
          empty_flags[t_idx] <= fin.empty;
          res.symbol_bits    <= (cur.kind == tslsb_pkg::K_RDROW) ? row_cap : fin.first;
          res.has_null       <= fin.nul;
          res.is_full        <= fin.full;
          res.is_empty       <= fin.empty;
          res_valid          <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    state == tslsb_pkg::ST_CLEAR |-> req_stall)
    else $error("request taken during clearing pass");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == tslsb_pkg::ST_SRC)
    else $error("accepted request did not start a fetch");

  a_we_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == tslsb_pkg::ST_CLEAR || state == tslsb_pkg::ST_WALK))
    else $error("follow row write outside walk or clear");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == tslsb_pkg::ST_DONE && res_valid && res_stall |=> state == tslsb_pkg::ST_DONE)
    else $error("result overwritten while stalled");

endmodule

@@ verif/two_symbol_lookahead_set_bank_test.sv @@
`timescale 1ns / 100ps

module two_symbol_lookahead_set_bank_test;

  class set_bank_scoreboard;
    logic [31:0] rows [16][32];
    logic [31:0] first [16];
    logic [31:0] single [16];
    bit nul [16];
    bit full [16];
    bit empty [16];
    tslsb_pkg::res_t pending [$];
    int errors;

    function void clear_all();
      for (int t = 0; t < 16; t++) begin
        for (int i = 0; i < 32; i++) rows[t][i] = '0;
        first[t] = '0;
        single[t] = '0;
        nul[t] = 1'b0;
        full[t] = 1'b0;
        empty[t] = 1'b1;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void merge(int t, int s);
      if (nul[s]) nul[t] = 1'b1;
      if (empty[s]) return;
      first[t] |= first[s];
      single[t] |= single[s];
      for (int i = 0; i < 32; i++) rows[t][i] |= rows[s][i];
      if (empty[t] && full[s]) full[t] = 1'b1;
      empty[t] = 1'b0;
    endfunction

    function void note_request(tslsb_pkg::req_t r);
      int t;
      int s;
      int len;
      tslsb_pkg::res_t e;
      logic [31:0] abit;
      logic [31:0] bbit;
      logic [31:0] sfirst;
      t = int'(r.target_set);
      s = int'(r.source_set);
      len = (r.string_length > 2'd2) ? 2 : int'(r.string_length);
      abit = 32'd1 << r.token_a;
      bbit = 32'd1 << r.token_b;
      case (r.kind)
        tslsb_pkg::K_CLEAR: begin
          for (int i = 0; i < 32; i++) rows[t][i] = '0;
          first[t] = '0;
          single[t] = '0;
          nul[t] = 1'b0;
          full[t] = 1'b0;
          empty[t] = 1'b1;
        end
        tslsb_pkg::K_ADD: begin
          if (len == 0) begin
            nul[t] = 1'b1;
          end else if (len == 1) begin
            single[t] |= abit;
            first[t] |= abit;
            full[t] = 1'b0;
            empty[t] = 1'b0;
          end else begin
            first[t] |= abit;
            rows[t][r.token_a] |= bbit;
            if (empty[t]) begin
              empty[t] = 1'b0;
              full[t] = 1'b1;
            end
          end
        end
        tslsb_pkg::K_UNION: merge(t, s);
        tslsb_pkg::K_MAXU: begin
          if (!empty[s]) begin
            for (int i = 0; i < 32; i++) begin
              if (rows[t][i] != 0) first[t][i] = 1'b1;
              rows[t][i] |= rows[s][i];
            end
            if (empty[t]) begin
              empty[t] = 1'b0;
              full[t] = 1'b1;
            end
          end
        end
        tslsb_pkg::K_APPTOK: begin
          for (int i = 0; i < 32; i++) if (single[t][i]) rows[t][i] |= abit;
          single[t] = '0;
          if (nul[t]) begin
            nul[t] = 1'b0;
            first[t] |= abit;
            single[t] |= abit;
            full[t] = 1'b0;
            empty[t] = 1'b0;
          end else if (!empty[t]) begin
            full[t] = 1'b1;
          end
        end
        tslsb_pkg::K_APPSET: begin
          if (!empty[s]) begin
            if (!empty[t]) begin
              // source first set read live, after any same-slot update above
              sfirst = first[s];
              for (int i = 0; i < 32; i++) if (single[t][i]) rows[t][i] |= sfirst;
              if (!nul[s]) begin
                single[t] = '0;
                if (!nul[t]) full[t] = 1'b1;
              end
            end
            if (nul[t]) begin
              nul[t] = 1'b0;
              merge(t, s);
            end
          end
        end
        default: ;
      endcase
      e.symbol_bits = (r.kind == tslsb_pkg::K_RDROW) ? rows[t][r.token_a] : first[t];
      e.has_null = nul[t];
      e.is_full = full[t];
      e.is_empty = empty[t];
      pending.push_back(e);
    endfunction

    function void check_result(tslsb_pkg::res_t got);
      tslsb_pkg::res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.symbol_bits !== e.symbol_bits || got.has_null !== e.has_null ||
          got.is_full !== e.is_full || got.is_empty !== e.is_empty) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected bits %h n%b f%b e%b, got bits %h n%b f%b e%b",
                   e.symbol_bits, e.has_null, e.is_full, e.is_empty,
                   got.symbol_bits, got.has_null, got.is_full, got.is_empty);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  tslsb_pkg::req_t req;
  logic res_valid;
  logic res_stall;
  tslsb_pkg::res_t res;

  set_bank_scoreboard board;
  int burst_left;
  bit stall_mode;

  two_symbol_lookahead_set_bank DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("two_symbol_lookahead_set_bank_test failed");
    $finish;
  end

  // receiver side: stall pattern alternates between quiet and busy stretches
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      res_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) board.check_result(res);
  end

  task automatic send_request(tslsb_pkg::req_t r);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(r);
    @(negedge clk);
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain_requests();
    req_valid <= 1'b0;
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  task automatic directed_request(tslsb_pkg::kind_t k, int t, int s, int a, int b, int len);
    tslsb_pkg::req_t r;
    r.kind = k;
    r.target_set = 4'(t);
    r.source_set = 4'(s);
    r.token_a = 5'(a);
    r.token_b = 5'(b);
    r.string_length = 2'(len);
    send_request(r);
  endtask

  function automatic tslsb_pkg::req_t random_request();
    tslsb_pkg::req_t r;
    logic [31:0] w;
    w = $urandom;
    r = w[$bits(tslsb_pkg::req_t)-1:0];
    // well-formed build-up mostly uses few slots so sets interact
    if ($urandom_range(0, 3) != 0) begin
      r.target_set = 4'($urandom_range(0, 3));
      r.source_set = 4'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 2) == 0) r.kind = tslsb_pkg::K_ADD;
    if (r.kind == tslsb_pkg::K_CLEAR && $urandom_range(0, 2) != 0) r.kind = tslsb_pkg::K_ADD;
    return r;
  endfunction

  initial begin
    req_valid = 1'b0;
    req = '0;
    rst = 1'b1;
    burst_left = 4;
    board = new();
    board.clear_all();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_request(tslsb_pkg::K_RDFIRST, 0, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_ADD, 0, 0, 0, 31, 2);
    directed_request(tslsb_pkg::K_ADD, 0, 0, 31, 0, 1);
    directed_request(tslsb_pkg::K_ADD, 1, 0, 5, 7, 3);
    directed_request(tslsb_pkg::K_ADD, 1, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_RDROW, 0, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_RDROW, 1, 0, 5, 0, 0);
    directed_request(tslsb_pkg::K_UNION, 2, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_UNION, 2, 2, 0, 0, 0);
    directed_request(tslsb_pkg::K_MAXU, 1, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_MAXU, 3, 3, 0, 0, 0);
    directed_request(tslsb_pkg::K_MAXU, 15, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_APPTOK, 0, 0, 9, 0, 0);
    directed_request(tslsb_pkg::K_ADD, 4, 0, 3, 0, 0);
    directed_request(tslsb_pkg::K_APPTOK, 4, 0, 17, 0, 0);
    directed_request(tslsb_pkg::K_APPSET, 1, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_APPSET, 0, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_APPSET, 5, 1, 0, 0, 0);
    directed_request(tslsb_pkg::K_RDROW, 0, 0, 31, 0, 0);
    directed_request(tslsb_pkg::K_CLEAR, 0, 0, 0, 0, 0);
    directed_request(tslsb_pkg::K_RDFIRST, 0, 0, 0, 0, 0);

    // hold off until the bank has drained
    drain_requests();

    for (int n = 0; n < 700; n++) begin
      send_request(random_request());
      if (n == 350) drain_requests();
    end

    drain_requests();
    repeat (100) @(negedge clk);
    if (board.errors == 0) begin
      $display("two_symbol_lookahead_set_bank_test passed");
    end else begin
      $display("two_symbol_lookahead_set_bank_test failed");
    end
    $finish;
  end

endmodule
